// ===== rtl/core/lrukv_pkg.sv =====
// shared constants, command codes and the update plan type for the lru key/value cache
package lrukv_pkg;

    localparam int ENTRIES_DEFAULT    = 16;
    localparam int KEY_BITS_DEFAULT   = 32;
    localparam int VALUE_BITS_DEFAULT = 32;

    // capacity register
    localparam int                CFG_W          = 5;
    localparam logic [CFG_W-1:0]  ACTIVE_RESET   = 5'd16;

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // what the store does with the current transaction
    typedef struct packed {
        logic update;       // some entry is selected and made most recent
        logic hit;          // key already present
        logic insert;       // fill a free slot, everyone else ages
        logic write_key;    // selected slot takes the new key
        logic write_value;  // selected slot takes the new value
        logic read_hit;     // get that hit, value goes out
    } t_plan;

endpackage

// ===== rtl/core/lru_key_value_cache.sv =====
// top level of the fully associative lru key/value cache
// A get or put transaction is taken at every clock edge where start is high; busy never rises,
// so one transaction per cycle is sustained indefinitely. The request is registered, then in
// the following cycle all entries compare their key in parallel, the recency ranks update and
// the result is registered: o_done rises with the result register and stays high for a single
// cycle per transaction, and the result, o_hit and o_read_value, is taken while o_done is high.
// That parallel compare and rank update over every entry is what sets the rate. The receiver
// cannot stall, so results must be taken as they appear. Reset clears all valid bits at once;
// there is no clearing pass. The user must write the capacity register through the cfg channel
// (always ready) only while no transaction is in flight; the block itself does not enforce it.
module lru_key_value_cache #(
    parameter int ENTRIES    = lrukv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request side
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [VALUE_BITS-1:0]       i_value,
    // result side
    output logic                        o_done,
    output logic                        o_hit,
    output logic [VALUE_BITS-1:0]       o_read_value,
    // capacity register
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lrukv_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // request register
    logic                   r_req_valid;
    logic                   r_req_command;
    logic [KEY_BITS-1:0]    r_req_key;
    logic [VALUE_BITS-1:0]  r_req_value;

    // capacity register
    logic [lrukv_pkg::CFG_W-1:0] r_active_entries;

    // result register
    logic                   r_done;
    logic                   r_hit;
    logic [VALUE_BITS-1:0]  r_read_value;

    // between lookup and store
    lrukv_pkg::t_plan       w_plan;
    logic [ENTRIES-1:0]     w_sel_oh;
    logic [RANK_W-1:0]      w_limit;
    logic [VALUE_BITS-1:0]  w_hit_value;
    logic [ENTRIES-1:0]     w_entry_valid;
    logic [KEY_BITS-1:0]    w_entry_key   [ENTRIES];
    logic [VALUE_BITS-1:0]  w_entry_value [ENTRIES];
    logic [RANK_W-1:0]      w_entry_rank  [ENTRIES];
    logic [CNT_W-1:0]       w_filled;

    // every cycle is a valid slot for a new transaction
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid      <= 1'b0;
            r_active_entries <= lrukv_pkg::ACTIVE_RESET;
            r_done           <= 1'b0;
        end else begin
            r_req_valid <= start && !busy;
            r_done      <= r_req_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_entries <= i_cfg_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req_command <= i_command;
            r_req_key     <= i_key;
            r_req_value   <= i_value;
        end
        r_hit        <= w_plan.hit;
        r_read_value <= w_plan.read_hit ? w_hit_value : '0;
    end

    lrukv_lookup #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_lookup (
        .i_req_valid      (r_req_valid),
        .i_req_command    (r_req_command),
        .i_req_key        (r_req_key),
        .i_entry_valid    (w_entry_valid),
        .i_entry_key      (w_entry_key),
        .i_entry_value    (w_entry_value),
        .i_entry_rank     (w_entry_rank),
        .i_filled         (w_filled),
        .i_active_entries (r_active_entries),
        .o_plan           (w_plan),
        .o_sel_oh         (w_sel_oh),
        .o_limit          (w_limit),
        .o_hit_value      (w_hit_value)
    );

    lrukv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_plan        (w_plan),
        .i_sel_oh      (w_sel_oh),
        .i_limit       (w_limit),
        .i_key         (r_req_key),
        .i_value       (r_req_value),
        .o_entry_valid (w_entry_valid),
        .o_entry_key   (w_entry_key),
        .o_entry_value (w_entry_value),
        .o_entry_rank  (w_entry_rank),
        .o_filled      (w_filled)
    );

    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;

    // every registered request produces exactly one result in the following cycle
    a_done_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid |=> o_done)
        else $error("request did not produce a result");

    // fill count tracks the number of valid slots
    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_entry_valid) == int'(w_filled))
        else $error("fill count out of step with valid bits");

    // an updating transaction always picks exactly one slot
    a_single_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_plan.update |-> $onehot(w_sel_oh))
        else $error("update selected no slot or several slots");

    // a miss never returns data
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_read_value == '0))
        else $error("miss returned a non-zero value");

endmodule

// ===== rtl/core/lrukv_lookup.sv =====
// parallel key match, slot selection and capacity check for one transaction
module lrukv_lookup #(
    parameter int ENTRIES    = lrukv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            i_req_valid,
    input  logic                            i_req_command,
    input  logic [KEY_BITS-1:0]             i_req_key,
    input  logic [ENTRIES-1:0]              i_entry_valid,
    input  logic [KEY_BITS-1:0]             i_entry_key   [ENTRIES],
    input  logic [VALUE_BITS-1:0]           i_entry_value [ENTRIES],
    input  logic [$clog2(ENTRIES)-1:0]      i_entry_rank  [ENTRIES],
    input  logic [$clog2(ENTRIES+1)-1:0]    i_filled,
    input  logic [lrukv_pkg::CFG_W-1:0]     i_active_entries,
    output lrukv_pkg::t_plan                o_plan,
    output logic [ENTRIES-1:0]              o_sel_oh,
    output logic [$clog2(ENTRIES)-1:0]      o_limit,
    output logic [VALUE_BITS-1:0]           o_hit_value
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lrukv_pkg::CFG_W) ? CNT_W : lrukv_pkg::CFG_W;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] hit_oh;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] victim_oh;
    logic [RANK_W-1:0]  hit_rank;
    logic [RANK_W-1:0]  oldest_rank;
    logic [CNT_W-1:0]   filled_m1;
    logic [CMP_W-1:0]   cap_raw;
    logic [CMP_W-1:0]   cap;
    logic [CMP_W-1:0]   fill_ext;
    logic               is_put;
    logic               any_hit;
    logic               full;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = i_entry_valid[i] && (i_entry_key[i] == i_req_key);
        end
    end

    // lowest matching slot, lowest free slot
    assign hit_oh  = match & (~match + ENTRIES'(1));
    assign free_oh = ~i_entry_valid & (i_entry_valid + ENTRIES'(1));
    assign any_hit = |match;

    // ranks of valid slots form 0..filled-1, so the oldest is unique
    assign filled_m1   = i_filled - CNT_W'(1);
    assign oldest_rank = filled_m1[RANK_W-1:0];

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            victim_oh[i] = i_entry_valid[i] && (i_entry_rank[i] == oldest_rank);
        end
    end

    always_comb begin
        hit_rank    = '0;
        o_hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_rank    = hit_rank    | ({RANK_W{hit_oh[i]}} & i_entry_rank[i]);
            o_hit_value = o_hit_value | ({VALUE_BITS{hit_oh[i]}} & i_entry_value[i]);
        end
    end

    // capacity clamped to 1..ENTRIES
    assign cap_raw  = CMP_W'(i_active_entries);
    assign fill_ext = CMP_W'(i_filled);

    always_comb begin
        if (cap_raw == '0) begin
            cap = CMP_W'(1);
        end else if (cap_raw > CMP_W'(ENTRIES)) begin
            cap = CMP_W'(ENTRIES);
        end else begin
            cap = cap_raw;
        end
    end

    assign full   = fill_ext >= cap;
    assign is_put = (i_req_command == lrukv_pkg::CMD_PUT);

    always_comb begin
        o_plan.hit         = any_hit;
        o_plan.update      = i_req_valid && (any_hit || is_put);
        o_plan.insert      = i_req_valid && !any_hit && is_put && !full;
        o_plan.write_key   = i_req_valid && !any_hit && is_put;
        o_plan.write_value = i_req_valid && is_put;
        o_plan.read_hit    = any_hit && !is_put;
    end

    assign o_sel_oh = any_hit ? hit_oh : (full ? victim_oh : free_oh);
    assign o_limit  = any_hit ? hit_rank : oldest_rank;

endmodule

// ===== rtl/core/lrukv_store.sv =====
// entry registers: valid bits, keys, values, recency ranks and fill count
module lrukv_store #(
    parameter int ENTRIES    = lrukv_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lrukv_pkg::t_plan                i_plan,
    input  logic [ENTRIES-1:0]              i_sel_oh,
    input  logic [$clog2(ENTRIES)-1:0]      i_limit,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [VALUE_BITS-1:0]           i_value,
    output logic [ENTRIES-1:0]              o_entry_valid,
    output logic [KEY_BITS-1:0]             o_entry_key   [ENTRIES],
    output logic [VALUE_BITS-1:0]           o_entry_value [ENTRIES],
    output logic [$clog2(ENTRIES)-1:0]      o_entry_rank  [ENTRIES],
    output logic [$clog2(ENTRIES+1)-1:0]    o_filled
);

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]     r_valid;
    logic [ENTRIES-1:0]     n_valid;
    logic [RANK_W-1:0]      r_rank [ENTRIES];
    logic [RANK_W-1:0]      n_rank [ENTRIES];
    logic [KEY_BITS-1:0]    r_key  [ENTRIES];
    logic [VALUE_BITS-1:0]  r_value[ENTRIES];
    logic [CNT_W-1:0]       r_filled;
    logic [CNT_W-1:0]       n_filled;

    always_comb begin
        n_valid  = r_valid;
        n_rank   = r_rank;
        n_filled = r_filled;
        if (i_plan.update) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_sel_oh[i]) begin
                    n_rank[i]  = '0;
                    n_valid[i] = 1'b1;
                end else if (r_valid[i] && (i_plan.insert || (r_rank[i] < i_limit))) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
            if (i_plan.insert) begin
                n_filled = r_filled + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_filled <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid  <= n_valid;
            r_filled <= n_filled;
            r_rank   <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_sel_oh[i] && i_plan.write_key) begin
                r_key[i] <= i_key;
            end
            if (i_sel_oh[i] && i_plan.write_value) begin
                r_value[i] <= i_value;
            end
        end
    end

    assign o_entry_valid = r_valid;
    assign o_entry_key   = r_key;
    assign o_entry_value = r_value;
    assign o_entry_rank  = r_rank;
    assign o_filled      = r_filled;

endmodule
